// File: rtl/core/sfmt_style_random_word_generator_macros.svh
// Assertion macros shared by the generator RTL.
// Each macro checks one implication on i_clk, disabled while i_rst_n is low.
`ifndef SFMT_STYLE_RANDOM_WORD_GENERATOR_MACROS_SVH
`define SFMT_STYLE_RANDOM_WORD_GENERATOR_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SFMT_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SFMT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/core/sfmt_pkg.sv
// Shared types, constants and the regeneration function of the generator.
// Used by every module in rtl/core; it depends on nothing else.
`default_nettype none

package sfmt_pkg;

    localparam int BLOCK_ENTRIES = 155;
    localparam int MEM_DEPTH     = BLOCK_ENTRIES + 1;
    localparam int ADDR_W        = $clog2(MEM_DEPTH);
    localparam int LANE_W        = 2;
    localparam int LANES_TOTAL   = MEM_DEPTH * 4;
    localparam int BLOCK_LANES   = BLOCK_ENTRIES * 4;
    localparam int POS_W         = 10;
    localparam int QUEUE_DEPTH   = 4;

    localparam logic [ADDR_W-1:0] ENTRY_LAST = ADDR_W'(BLOCK_ENTRIES - 1);
    localparam logic [ADDR_W-1:0] ACC_ENTRY  = ADDR_W'(BLOCK_ENTRIES);
    localparam logic [ADDR_W-1:0] REC_POS    = ADDR_W'(89);
    localparam logic [POS_W-1:0]  POS_END    = POS_W'(BLOCK_LANES);
    localparam logic [POS_W-1:0]  LANE_LAST  = POS_W'(LANES_TOTAL - 1);

    localparam int REC_SHIFT_C = 18;
    localparam int REC_SHIFT_B = 3;
    localparam logic [31:0]  SEED_MULT = 32'd1812433253;
    localparam logic [127:0] REC_MASK  =
        {32'hfefe7bef, 32'heffffbff, 32'hfffbffff, 32'h7f7fffff};

    typedef enum logic {
        CMD_SEED = 1'b0,
        CMD_NEXT = 1'b1
    } t_cmd;

    typedef struct packed {
        t_cmd        cmd;
        logic [31:0] seed;
    } t_req;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEED,
        ST_GEN_LOAD,
        ST_GEN_PRIME,
        ST_GEN_RUN,
        ST_GEN_ACC,
        ST_READ
    } t_back_state;

    function automatic logic [127:0] gen_word(input logic [127:0] a,
                                              input logic [127:0] b,
                                              input logic [127:0] c,
                                              input logic [127:0] d);
        logic [127:0] cs;
        logic [127:0] bs;
        logic [127:0] dsh;
        logic [127:0] ash;
        for (int k = 0; k < 4; k++) begin
            cs[k*32 +: 32] = c[k*32 +: 32] << REC_SHIFT_C;
            bs[k*32 +: 32] = b[k*32 +: 32] >> REC_SHIFT_B;
        end
        dsh = {d[127:96], d[95:64], d[31:0], d[63:32]};
        ash = a << 8;
        return cs ^ dsh ^ a ^ ash ^ (bs & REC_MASK);
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/sfmt_front.sv
// Input stage: registers one request from the slave stream and decodes its kind.
// Depends on sfmt_pkg for the request type; feeds sfmt_queue.
`default_nettype none

module sfmt_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          s_axis_tvalid,
    output logic               s_axis_tready,
    input  wire logic [31:0]   s_axis_tdata,  // [31:0] seed_value
    input  wire logic [0:0]    s_axis_tuser,  // [0] cmd
    input  wire logic          i_q_full,
    output logic               o_push,
    output sfmt_pkg::t_req     o_req
);

    logic           r_valid;
    sfmt_pkg::t_req r_req;
    logic           load;

    assign o_push        = r_valid && !i_q_full;
    assign s_axis_tready = !r_valid || !i_q_full;
    assign load          = s_axis_tvalid && s_axis_tready;
    assign o_req         = r_req;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= 1'b1;
        end else if (o_push) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_req.cmd  <= s_axis_tuser[0] ? sfmt_pkg::CMD_NEXT : sfmt_pkg::CMD_SEED;
            r_req.seed <= s_axis_tdata;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/sfmt_queue.sv
// Short request queue between the input stage and the generator engine.
// Depends on sfmt_pkg for the request type.
`default_nettype none

module sfmt_queue #(
    parameter int DEPTH = sfmt_pkg::QUEUE_DEPTH
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    input  wire sfmt_pkg::t_req  i_req,
    input  wire logic            i_pop,
    output sfmt_pkg::t_req       o_head,
    output logic                 o_empty,
    output logic                 o_full
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    sfmt_pkg::t_req   r_slot [DEPTH];
    logic [PTR_W-1:0] r_wptr;
    logic [PTR_W-1:0] r_rptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push;
    logic             do_pop;

    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == CNT_FULL);
    assign o_head  = r_slot[r_rptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= (r_wptr == PTR_LAST) ? '0 : r_wptr + PTR_W'(1);
            end
            if (do_pop) begin
                r_rptr <= (r_rptr == PTR_LAST) ? '0 : r_rptr + PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wptr] <= i_req;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/sfmt_back.sv
// Generator engine: state memory, seeding, block regeneration and word readout.
// Depends on sfmt_pkg and the assertion macros; pops requests from sfmt_queue.
`default_nettype none
`include "sfmt_style_random_word_generator_macros.svh"

module sfmt_back (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire sfmt_pkg::t_req  i_head,
    input  wire logic            i_q_empty,
    output logic                 o_pop,
    output logic                 m_axis_tvalid,
    input  wire logic            m_axis_tready,
    output logic [31:0]          m_axis_tdata  // [31:0] random_word
);

    localparam int AW = sfmt_pkg::ADDR_W;
    localparam int PW = sfmt_pkg::POS_W;
    localparam int LW = sfmt_pkg::LANE_W;

    sfmt_pkg::t_back_state r_state;
    sfmt_pkg::t_back_state n_state;

    logic [127:0] r_mem [sfmt_pkg::MEM_DEPTH];
    logic [127:0] r_rd_a;
    logic [127:0] r_rd_b;

    logic [PW-1:0] r_pos;
    logic [PW-1:0] r_lane;
    logic [31:0]   r_seed;
    logic [31:0]   r_prod;
    logic [95:0]   r_sbuf;
    logic [127:0]  r_c;
    logic [127:0]  r_d;
    logic [AW-1:0] r_gi;
    logic [AW-1:0] r_bi;
    logic          r_out_valid;
    logic [31:0]   r_out_data;

    logic          out_free;
    logic          head_ok;
    logic          seed_done;
    logic [31:0]   seed_v;
    logic [31:0]   seed_x;
    logic [31:0]   n_prod;
    logic [127:0]  gen_nw;
    logic [AW-1:0] bi_next;
    logic [AW-1:0] addr_a;
    logic [AW-1:0] addr_b;
    logic          mem_we;
    logic [AW-1:0] waddr;
    logic [127:0]  wdata;

    assign out_free  = !r_out_valid || m_axis_tready;
    assign head_ok   = !i_q_empty &&
                       (i_head.cmd == sfmt_pkg::CMD_SEED || out_free);
    assign seed_done = (r_lane == sfmt_pkg::LANE_LAST);
    assign seed_v    = (r_lane == '0) ? r_seed : r_prod + 32'(r_lane);
    assign seed_x    = seed_v ^ (seed_v >> 30);
    assign n_prod    = seed_x * sfmt_pkg::SEED_MULT;
    assign gen_nw    = sfmt_pkg::gen_word(r_rd_a, r_rd_b, r_c, r_d);
    assign bi_next   = (r_bi == sfmt_pkg::ENTRY_LAST) ? '0 : r_bi + AW'(1);

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    always_comb begin
        n_state = r_state;
        case (r_state)
            sfmt_pkg::ST_IDLE: begin
                if (head_ok) begin
                    if (i_head.cmd == sfmt_pkg::CMD_SEED) begin
                        n_state = sfmt_pkg::ST_SEED;
                    end else if (r_pos >= sfmt_pkg::POS_END) begin
                        n_state = sfmt_pkg::ST_GEN_LOAD;
                    end else begin
                        n_state = sfmt_pkg::ST_READ;
                    end
                end
            end
            sfmt_pkg::ST_SEED: begin
                if (seed_done) begin
                    n_state = sfmt_pkg::ST_IDLE;
                end
            end
            sfmt_pkg::ST_GEN_LOAD:  n_state = sfmt_pkg::ST_GEN_PRIME;
            sfmt_pkg::ST_GEN_PRIME: n_state = sfmt_pkg::ST_GEN_RUN;
            sfmt_pkg::ST_GEN_RUN: begin
                if (r_gi == sfmt_pkg::ENTRY_LAST) begin
                    n_state = sfmt_pkg::ST_GEN_ACC;
                end
            end
            sfmt_pkg::ST_GEN_ACC: n_state = sfmt_pkg::ST_READ;
            sfmt_pkg::ST_READ:    n_state = sfmt_pkg::ST_IDLE;
            default:              n_state = sfmt_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_pop  = 1'b0;
        addr_a = r_pos[PW-1:LW];
        addr_b = sfmt_pkg::ACC_ENTRY;
        mem_we = 1'b0;
        waddr  = r_gi;
        wdata  = gen_nw;
        case (r_state)
            sfmt_pkg::ST_IDLE: begin
                o_pop = head_ok;
            end
            sfmt_pkg::ST_SEED: begin
                mem_we = (r_lane[LW-1:0] == 2'd3);
                waddr  = r_lane[PW-1:LW];
                wdata  = {seed_v, r_sbuf};
            end
            sfmt_pkg::ST_GEN_LOAD: begin
                addr_a = sfmt_pkg::ENTRY_LAST;
                addr_b = sfmt_pkg::ACC_ENTRY;
            end
            sfmt_pkg::ST_GEN_PRIME: begin
                addr_a = '0;
                addr_b = sfmt_pkg::REC_POS;
            end
            sfmt_pkg::ST_GEN_RUN: begin
                mem_we = 1'b1;
                addr_a = r_gi + AW'(1);
                addr_b = bi_next;
            end
            sfmt_pkg::ST_GEN_ACC: begin
                mem_we = 1'b1;
                waddr  = sfmt_pkg::ACC_ENTRY;
                wdata  = r_d;
                addr_a = '0;
            end
            sfmt_pkg::ST_READ: begin
                o_pop = 1'b0;
            end
            default: begin
                o_pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[waddr] <= wdata;
        end
        r_rd_a <= r_mem[addr_a];
        r_rd_b <= r_mem[addr_b];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= sfmt_pkg::ST_IDLE;
            r_pos       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == sfmt_pkg::ST_SEED && seed_done) begin
                r_pos <= sfmt_pkg::POS_END;
            end else if (r_state == sfmt_pkg::ST_GEN_ACC) begin
                r_pos <= '0;
            end else if (r_state == sfmt_pkg::ST_READ) begin
                r_pos <= r_pos + PW'(1);
            end
            if (r_state == sfmt_pkg::ST_READ) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            sfmt_pkg::ST_IDLE: begin
                r_seed <= i_head.seed;
                r_lane <= '0;
            end
            sfmt_pkg::ST_SEED: begin
                r_prod <= n_prod;
                r_lane <= r_lane + PW'(1);
                case (r_lane[LW-1:0])
                    2'd0:    r_sbuf[31:0]  <= seed_v;
                    2'd1:    r_sbuf[63:32] <= seed_v;
                    2'd2:    r_sbuf[95:64] <= seed_v;
                    default: r_sbuf        <= r_sbuf;
                endcase
            end
            sfmt_pkg::ST_GEN_PRIME: begin
                r_c  <= r_rd_a;
                r_d  <= r_rd_b;
                r_gi <= '0;
                r_bi <= sfmt_pkg::REC_POS;
            end
            sfmt_pkg::ST_GEN_RUN: begin
                r_c  <= gen_nw;
                r_d  <= r_d ^ gen_nw;
                r_gi <= r_gi + AW'(1);
                r_bi <= bi_next;
            end
            sfmt_pkg::ST_READ: begin
                r_out_data <= r_rd_a[r_pos[LW-1:0]*32 +: 32];
            end
            default: begin
                r_lane <= r_lane;
            end
        endcase
    end

    `SFMT_ASSERT_SAME(a_pos_in_range, 1'b1, r_pos <= sfmt_pkg::POS_END, "read position beyond block")
    `SFMT_ASSERT_SAME(a_out_slot_free, r_state == sfmt_pkg::ST_READ, !r_out_valid, "output register overwritten")
    `SFMT_ASSERT_NEXT(a_regen_restarts, r_state == sfmt_pkg::ST_GEN_ACC, r_state == sfmt_pkg::ST_READ && r_pos == '0, "regeneration did not restart reading")
    `SFMT_ASSERT_SAME(a_no_pop_in_work, o_pop, r_state == sfmt_pkg::ST_IDLE && !i_q_empty, "request taken while engine busy")

endmodule

`default_nettype wire

// File: rtl/core/sfmt_style_random_word_generator.sv
// Top level of the SIMD-style random word generator with a 156-entry, 128-bit state memory.
// Connects sfmt_front, sfmt_queue and sfmt_back; parameters come from sfmt_pkg.
//
// Requests arrive on the slave stream: tuser[0] is the command (0 seeds the
// generator with tdata, 1 asks for the next 32-bit word). Only a word request
// gives a result, one word on the master stream tdata.
// A request passes an input register and a four-entry queue before the engine
// takes it. A word request is served from the read port of the state memory;
// the engine pops it in its idle state and registers the word in its read state.
// A seed request is taken in the idle state; the seed state then fills one
// 32-bit lane per cycle through the multiply.
// After 620 words, and on the first word request after a seed, the block is
// regenerated first through the load, prime, run and accumulate states, one
// 128-bit entry per cycle over two read ports.
// Reset clears the handshake and position state; the state memory holds
// nothing until the first seed, and words requested before it are undefined.
// When the receiver stalls, the word waits in the output register, the engine
// stops taking word requests, and the queue and input register keep filling
// before tready falls.
`default_nettype none

module sfmt_style_random_word_generator #(
    parameter int QUEUE_DEPTH = sfmt_pkg::QUEUE_DEPTH
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          s_axis_tvalid,
    output logic               s_axis_tready,
    input  wire logic [31:0]   s_axis_tdata,  // [31:0] seed_value
    input  wire logic [0:0]    s_axis_tuser,  // [0] cmd
    output logic               m_axis_tvalid,
    input  wire logic          m_axis_tready,
    output logic [31:0]        m_axis_tdata   // [31:0] random_word
);

    sfmt_pkg::t_req push_req;
    sfmt_pkg::t_req head_req;
    logic           push;
    logic           pop;
    logic           q_full;
    logic           q_empty;

    sfmt_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .i_q_full      (q_full),
        .o_push        (push),
        .o_req         (push_req)
    );

    sfmt_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_req   (push_req),
        .i_pop   (pop),
        .o_head  (head_req),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    sfmt_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_head        (head_req),
        .i_q_empty     (q_empty),
        .o_pop         (pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule

`default_nettype wire

// File: dv/tb_sfmt_style_random_word_generator.sv
`timescale 1ns / 1ps
// Testbench for sfmt_style_random_word_generator: seeds the generator, requests words
// with random stalls on both streams and checks each word against its own predictor.
// Depends on sfmt_pkg and the generator RTL only.

class sfmt_scoreboard;
    localparam int ENTRIES = 155;
    localparam int WORDS_PER_BLOCK = ENTRIES * 4;
    localparam int LANE_COUNT = (ENTRIES + 1) * 4;
    localparam int FAR_OFFSET = 89;
    localparam logic [31:0] SEED_STEP = 32'd1812433253;

    logic [127:0] entry [ENTRIES + 1];
    logic [9:0]   word_pos;
    logic [31:0]  expected_words [$];
    int           errors;

    function new();
        foreach (entry[i]) entry[i] = '0;
        word_pos = '0;
        errors = 0;
    endfunction

    function int pending();
        return expected_words.size();
    endfunction

    function logic [31:0] lane_mask(int k);
        case (k)
            0: return 32'h7f7fffff;
            1: return 32'hfffbffff;
            2: return 32'heffffbff;
            default: return 32'hfefe7bef;
        endcase
    endfunction

    function void load_seed(logic [31:0] seed);
        logic [31:0] prev;
        logic [31:0] cur;
        prev = seed;
        entry[0][31:0] = seed;
        for (int n = 1; n < LANE_COUNT; n++) begin
            cur = SEED_STEP * (prev ^ (prev >> 30)) + 32'(n);
            entry[n / 4][(n % 4) * 32 +: 32] = cur;
            prev = cur;
        end
    endfunction

    function void refill_block();
        logic [127:0] last;
        logic [127:0] acc;
        logic [127:0] a;
        logic [127:0] far;
        logic [127:0] fresh;
        int src;
        last = entry[ENTRIES - 1];
        acc = entry[ENTRIES];
        for (int i = 0; i < ENTRIES; i++) begin
            a = entry[i];
            far = entry[(i + FAR_OFFSET) % ENTRIES];
            fresh = a ^ (a << 8);
            for (int k = 0; k < 4; k++) begin
                src = (k < 2) ? 1 - k : k;
                fresh[k*32 +: 32] ^= (last[k*32 +: 32] << 18) ^ acc[src*32 +: 32]
                    ^ ((far[k*32 +: 32] >> 3) & lane_mask(k));
            end
            entry[i] = fresh;
            last = fresh;
            acc ^= fresh;
        end
        entry[ENTRIES] = acc;
    endfunction

    function void note_request(sfmt_pkg::t_cmd cmd, logic [31:0] seed);
        if (cmd == sfmt_pkg::CMD_SEED) begin
            load_seed(seed);
            word_pos = 10'(WORDS_PER_BLOCK);
        end else begin
            if (word_pos >= WORDS_PER_BLOCK) begin
                refill_block();
                word_pos = '0;
            end
            expected_words.push_back(entry[word_pos[9:2]][word_pos[1:0] * 32 +: 32]);
            word_pos = word_pos + 10'd1;
        end
    endfunction

    function void check_word(logic [31:0] got);
        logic [31:0] want;
        if (expected_words.size() == 0) begin
            errors++;
            $display("%0t: word mismatch, expected none, actual %08h", $time, got);
            return;
        end
        want = expected_words.pop_front();
        if (got !== want) begin
            errors++;
            $display("%0t: word mismatch, expected %08h, actual %08h", $time, want, got);
        end
    endfunction
endclass

module tb_sfmt_style_random_word_generator;
    localparam int RANDOM_ITEMS = 830;
    localparam int LONG_RUN = 700;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;   // [31:0] seed_value
    logic [0:0]  s_axis_tuser = '0;   // [0] cmd
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;        // [31:0] random_word

    int src_idle_pct = 31;
    int sink_idle_pct = 78;
    sfmt_scoreboard sb = new();

    sfmt_style_random_word_generator dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(0, 99) >= sink_idle_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                sb.note_request(sfmt_pkg::t_cmd'(s_axis_tuser[0]), s_axis_tdata);
            end
            if (m_axis_tvalid && m_axis_tready) begin
                sb.check_word(m_axis_tdata);
            end
        end
    end

    task automatic send_request(input sfmt_pkg::t_cmd cmd, input logic [31:0] data);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= cmd;
        s_axis_tdata <= data;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    initial begin
        int random_nexts;
        random_nexts = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_request(sfmt_pkg::CMD_SEED, 32'h0000_0000);
        send_request(sfmt_pkg::CMD_NEXT, 32'h0000_0000);
        send_request(sfmt_pkg::CMD_NEXT, 32'hffff_ffff);
        send_request(sfmt_pkg::CMD_NEXT, $urandom());
        send_request(sfmt_pkg::CMD_SEED, 32'hffff_ffff);
        send_request(sfmt_pkg::CMD_NEXT, 32'hffff_ffff);
        send_request(sfmt_pkg::CMD_NEXT, 32'h0000_0000);
        send_request(sfmt_pkg::CMD_SEED, 32'h0000_0001);
        send_request(sfmt_pkg::CMD_SEED, 32'h8000_0000);
        send_request(sfmt_pkg::CMD_NEXT, $urandom());
        send_request(sfmt_pkg::CMD_NEXT, $urandom());
        send_request(sfmt_pkg::CMD_SEED, 32'h7fff_ffff);
        send_request(sfmt_pkg::CMD_NEXT, $urandom());
        send_request(sfmt_pkg::CMD_SEED, $urandom());

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == RANDOM_ITEMS / 3) begin
                src_idle_pct = 78;
                sink_idle_pct = 31;
            end
            if (n == 2 * RANDOM_ITEMS / 3) begin
                src_idle_pct = 0;
                sink_idle_pct = 0;
            end
            if (random_nexts >= LONG_RUN && $urandom_range(0, 59) == 0) begin
                send_request(sfmt_pkg::CMD_SEED, $urandom());
            end else begin
                send_request(sfmt_pkg::CMD_NEXT, $urandom());
                random_nexts++;
            end
        end
        s_axis_tvalid <= 1'b0;

        while (sb.pending() != 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("status: fail");
        $finish;
    end
endmodule
